// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that holds in every cycle, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/qbez_pkg.sv -----
// ----------------------------------------------------------------------------
// qbez_pkg
// Register indexes and reset control points of the quintic Bezier evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qbez_pkg;

  localparam int NUM_POINTS = 6;
  localparam int CFG_ADDR_BITS = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] REG_POINT0 = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_POINT5 = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RESOLUTION = 3'd6;

  localparam int RES_BITS = 10;
  localparam logic [RES_BITS-1:0] RES_RESET = 10'd100;
  localparam int IDX_BITS = 10;

  typedef int coord_list_t [NUM_POINTS];

  // Reset control points, one coordinate list per axis.
  localparam coord_list_t RESET_X = '{500, 550, 600, 600, 550, 500};
  localparam coord_list_t RESET_Y = '{500, 520, 540, 560, 580, 600};
  localparam coord_list_t RESET_Z = '{0, 0, 0, 0, 0, 0};

endpackage

`default_nettype wire

// ----- hdl/quintic_bezier_point_eval.sv -----
// ----------------------------------------------------------------------------
// quintic_bezier_point_eval
// Pipelined quintic Bezier point evaluator over six configured control points.
// ----------------------------------------------------------------------------
//  Channel | Signals                          | Contents
//  s_      | s_tvalid s_tready s_tdata[15:0]  | sample_index
//  m_      | m_tvalid m_tready m_tdata        | out_x, out_y, out_z
//  cfg_    | cfg_we cfg_addr cfg_data         | point0..5, resolution
//
// One sample enters per cycle unless the output stalls. The pipe is the
// restoring divider, an alignment stage and one quotient bit per stage,
// followed by ten stages of powers, basis, products, sums and rounding into
// the output register.
// All stages advance together whenever the output register is empty or is
// being drained, so a stall at the output holds every item in place.
// Reset (synchronous, active high) clears the valid bits and loads the
// default control points and a resolution of 100.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quintic_bezier_point_eval #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // s_tdata: sample_index in bits 9:0, zero above.
  input  wire logic                                        s_tvalid,
  output logic                                             s_tready,
  input  wire logic [15:0]                                 s_tdata,
  // m_tdata: out_x, then out_y, then out_z, from the lowest bit up.
  output logic                                             m_tvalid,
  input  wire logic                                        m_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]                m_tdata,
  input  wire logic                                        cfg_we,
  input  wire logic [qbez_pkg::CFG_ADDR_BITS-1:0]          cfg_addr,
  input  wire logic [3*COORD_BITS-1:0]                     cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = F + 5 + C;       // signed product width
  localparam int AW   = PW + 3;          // accumulator width
  localparam int BW   = F + 4;           // weighted basis width
  localparam int OW   = ((3*C+7)/8)*8;
  localparam int RB   = qbez_pkg::RES_BITS;
  localparam int NW   = qbez_pkg::IDX_BITS + F + 1;

  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam logic [2*F+1:0] HALF_P = (2*F+2)'(1) << (F-1);
  localparam logic signed [AW-1:0] HALF_A = AW'(1) << (F-1);
  localparam logic signed [AW-1:0] MAXC = (AW'(1) << (C-1)) - AW'(1);
  localparam logic signed [AW-1:0] MINC = -(AW'(1) << (C-1));

  // Configuration registers.
  logic [3*C-1:0] point [qbez_pkg::NUM_POINTS];
  logic [RB-1:0]  resolution;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
        point[k] <= {C'(qbez_pkg::RESET_Z[k]), C'(qbez_pkg::RESET_Y[k]),
                     C'(qbez_pkg::RESET_X[k])};
      end
      resolution <= qbez_pkg::RES_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == qbez_pkg::REG_RESOLUTION) begin
        resolution <= cfg_data[RB-1:0];
      end else if (cfg_addr <= qbez_pkg::REG_POINT5) begin
        point[cfg_addr] <= cfg_data;
      end
    end
  end

  // Fixed-point product with round half up; both operands are at most one.
  function automatic logic [F:0] fxm(input logic [F:0] a, input logic [F:0] b);
    logic [2*F+1:0] p;
    p = a * b + HALF_P;
    return p[2*F:F];
  endfunction

  // The whole pipe moves when the output stage can take a new value.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- Divider: t = round(index * 2^F / resolution) ----------
  logic          dv   [F+1];
  logic [RB-1:0] drem [F+1];
  logic [F-1:0]  dlo  [F+1];
  logic [F-1:0]  dq   [F+1];
  logic          done [F+1];

  logic [qbez_pkg::IDX_BITS-1:0] idx;
  logic [NW-1:0] num;
  logic [RB:0]   r0;
  logic          r0_hi;
  assign idx   = s_tdata[qbez_pkg::IDX_BITS-1:0];
  assign num   = {1'b0, idx, F'(0)} + NW'(resolution >> 1);
  assign r0    = (RB+1)'(num >> F);
  assign r0_hi = r0 >= {1'b0, resolution};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= r0_hi ? RB'(r0 - {1'b0, resolution}) : RB'(r0);
      dlo[0]  <= num[F-1:0];
      dq[0]   <= '0;
      done[0] <= (resolution == '0) || ({1'b0, idx} >= {1'b0, resolution}) || r0_hi;
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_div
    logic [RB:0] shf;
    logic        ge;
    assign shf = {drem[i-1], dlo[i-1][F-i]};
    assign ge  = shf >= {1'b0, resolution};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i] <= 1'b0;
      end else if (en) begin
        dv[i] <= dv[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[i] <= ge ? RB'(shf - {1'b0, resolution}) : RB'(shf);
        dlo[i]  <= dlo[i-1];
        dq[i]   <= dq[i-1] | (ge ? (F'(1) << (F-i)) : F'(0));
        done[i] <= done[i-1];
      end
    end
  end

  // ---------------- Powers of t and u ------------------------------------
  logic [8:0] pv;   // valid bits of the stages after the divider
  logic [F:0] ta, ua;
  logic [F:0] tb [1:2], ub [1:2];
  logic [F:0] tc [1:3], uc [1:3];
  logic [F:0] td [1:4], ud [1:4];
  logic [F:0] te [1:5], ue [1:5];
  logic [BW-1:0] bw [qbez_pkg::NUM_POINTS];
  logic signed [PW-1:0] prod [3][qbez_pkg::NUM_POINTS];
  logic signed [AW-1:0] psum [3][3];
  logic signed [AW-1:0] acc  [3];

  logic [F:0] t_div;
  assign t_div = done[F] ? ONE : {1'b0, dq[F]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[7:0], dv[F]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta <= t_div;
      ua <= ONE - t_div;

      tb[1] <= ta;         ub[1] <= ua;
      tb[2] <= fxm(ta, ta); ub[2] <= fxm(ua, ua);

      tc[1] <= tb[1];      uc[1] <= ub[1];
      tc[2] <= tb[2];      uc[2] <= ub[2];
      tc[3] <= fxm(tb[2], tb[1]); uc[3] <= fxm(ub[2], ub[1]);

      for (int k = 1; k <= 3; k++) begin
        td[k] <= tc[k];
        ud[k] <= uc[k];
      end
      td[4] <= fxm(tc[3], tc[1]); ud[4] <= fxm(uc[3], uc[1]);

      for (int k = 1; k <= 4; k++) begin
        te[k] <= td[k];
        ue[k] <= ud[k];
      end
      te[5] <= fxm(td[4], td[1]); ue[5] <= fxm(ud[4], ud[1]);

      // Bernstein terms with weights 1, 5, 10, 10, 5, 1 as shift-adds.
      bw[0] <= BW'(ue[5]);
      bw[1] <= (BW'(fxm(ue[4], te[1])) << 2) + BW'(fxm(ue[4], te[1]));
      bw[2] <= (BW'(fxm(ue[3], te[2])) << 3) + (BW'(fxm(ue[3], te[2])) << 1);
      bw[3] <= (BW'(fxm(ue[2], te[3])) << 3) + (BW'(fxm(ue[2], te[3])) << 1);
      bw[4] <= (BW'(fxm(ue[1], te[4])) << 2) + BW'(fxm(ue[1], te[4]));
      bw[5] <= BW'(te[5]);

      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < qbez_pkg::NUM_POINTS; k++) begin
          prod[a][k] <= signed'({1'b0, bw[k]}) * signed'(point[k][a*C +: C]);
        end
        for (int j = 0; j < 3; j++) begin
          psum[a][j] <= AW'(prod[a][2*j]) + AW'(prod[a][2*j+1]);
        end
        acc[a] <= psum[a][0] + psum[a][1] + psum[a][2];
      end
    end
  end

  // ---------------- Round to nearest and saturate -------------------------
  logic [C-1:0] coord_q [3];
  always_comb begin
    logic signed [AW-1:0] r;
    for (int a = 0; a < 3; a++) begin
      r = (acc[a] + HALF_A) >>> F;
      if (r > MAXC) begin
        coord_q[a] = MAXC[C-1:0];
      end else if (r < MINC) begin
        coord_q[a] = MINC[C-1:0];
      end else begin
        coord_q[a] = r[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pv[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OW'({coord_q[2], coord_q[1], coord_q[0]});
    end
  end

  // ---------------- Checks -------------------------------------------------
  `ASSERT_CLK(a_ready_follows_output, clk, rst, s_tready == (!m_tvalid || m_tready),
              "input ready does not follow the output stage")
  `ASSERT_CLK(a_t_in_range, clk, rst, !pv[0] || (ta <= ONE),
              "curve parameter above one")
  `ASSERT_CLK(a_t_u_sum, clk, rst, !pv[0] || ((ta + ua) == ONE),
              "t and u do not add up to one")

endmodule

`default_nettype wire
